/* src/lmf_pkg.sv */
// Shared constants, types and the key position table of the LED matrix framer.
package lmf_pkg;

  // Chain and grid geometry.
  localparam int unsigned LED_COUNT    = 61;
  localparam int unsigned GRID_COLUMNS = 14;
  localparam int unsigned GRID_ROWS    = 5;
  localparam int unsigned MAP_LEN      = 70;

  // Field widths.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned COL_W      = 4;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned SPI_BYTE_W = 8;
  localparam int unsigned PIXEL_W    = 3 * COLOR_W;

  // Derived widths.
  localparam int unsigned LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned POS_W     = ROW_W + COL_W;
  localparam int unsigned MAP_IDX_W = (MAP_LEN > 1) ? $clog2(MAP_LEN) : 1;
  localparam int unsigned MAP_VAL_W = 6;
  localparam int unsigned BIT_CNT_W = $clog2(PIXEL_W);

  // SPI byte patterns for one WS2812 bit.
  localparam logic [SPI_BYTE_W-1:0] BYTE_ONE  = 8'hf0;
  localparam logic [SPI_BYTE_W-1:0] BYTE_ZERO = 8'hc0;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_REFRESH = 2'd2
  } kind_e;

  // Grid key (row * GRID_COLUMNS + column) to LED number.
  localparam logic [MAP_VAL_W-1:0] KEY_TO_LED [MAP_LEN] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd10, 6'd11, 6'd12, 6'd13,
    6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
    6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
    6'd38, 6'd39, 6'd40, 6'd40,
    6'd41, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49,
    6'd50, 6'd51, 6'd52, 6'd52,
    6'd53, 6'd54, 6'd55, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56,
    6'd57, 6'd58, 6'd59, 6'd60
  };

  // Load request from the sequencer to the bit serializer.
  typedef struct packed {
    logic               valid;
    logic [PIXEL_W-1:0] color;
    logic               final_led;
  } ser_load_t;

endpackage

/* src/lmf_ifs.sv */
// Handshake channel interfaces of the LED matrix framer.
interface lmf_in_if;
  import lmf_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, kind, column, row, red, green, blue, input ready);
  modport sink   (input valid, kind, column, row, red, green, blue, output ready);
endinterface

interface lmf_out_if;
  import lmf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SPI_BYTE_W-1:0] spi_byte;
  logic                  last_of_led;
  logic                  last_of_frame;

  modport source (output valid, spi_byte, last_of_led, last_of_frame, input ready);
  modport sink   (input valid, spi_byte, last_of_led, last_of_frame, output ready);
endinterface

interface lmf_cfg_if;
  logic valid;
  logic ready;
  logic supply_enable;
  logic supply_level;

  modport source (output valid, supply_enable, input ready, supply_level);
  modport sink   (input valid, supply_enable, output ready, supply_level);
endinterface

/* src/lmf_ram.sv */
// Generic single write port RAM with registered read.
module lmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lmf_serializer.sv */
// Shift unit that turns one LED color word into its WS2812 SPI byte stream.
module lmf_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lmf_pkg::ser_load_t  load_i,
  output logic                busy_o,
  lmf_out_if.source           out_o
);
  import lmf_pkg::*;

  logic [PIXEL_W-1:0]   shift_q, shift_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 final_q, final_d;
  logic                 last_bit;

  assign last_bit = (cnt_q == BIT_CNT_W'(PIXEL_W - 1));

  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    final_d = final_q;
    if (!busy_q) begin
      if (load_i.valid) begin
        shift_d = load_i.color;
        final_d = load_i.final_led;
        cnt_d   = '0;
        busy_d  = 1'b1;
      end
    end else if (out_o.ready) begin
      // Colors go out most significant bit first: G, then R, then B.
      shift_d = {shift_q[PIXEL_W-2:0], 1'b0};
      cnt_d   = cnt_q + 1'b1;
      if (last_bit) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    final_q <= final_d;
  end

  assign busy_o              = busy_q;
  assign out_o.valid         = busy_q;
  assign out_o.spi_byte      = shift_q[PIXEL_W-1] ? BYTE_ONE : BYTE_ZERO;
  assign out_o.last_of_led   = last_bit;
  assign out_o.last_of_frame = last_bit & final_q;

endmodule

/* src/led_matrix_ws2812_spi_framer_core.sv */
// Top level of the WS2812 LED matrix frame store and SPI byte framer.
//
//   channel  direction  handshake        payload
//   in_i     sink       valid / ready    kind, column, row, red, green, blue
//   out_o    source     valid / ready    spi_byte, last_of_led, last_of_frame
//   cfg_i    sink       valid / ready    supply_enable (level shown on supply_level)
//
// A pixel write or a clear is done when it is accepted. A refresh is accepted in
// ST_IDLE, which starts the frame RAM read; ST_READ loads the color into the
// serializer shifter, which sends 24 SPI bytes, one per cycle while out_o is ready.
// The input is not ready while a refresh is in flight; a stalled output holds
// its byte and stretches the refresh by the stall. Reset clears all LED valid
// bits at once, so the frame reads as black right after reset with no sweep.
module led_matrix_ws2812_spi_framer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmf_in_if.sink     in_i,
  lmf_out_if.source  out_o,
  lmf_cfg_if.sink    cfg_i
);
  import lmf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                 state_q;
  logic [LED_IDX_W-1:0]   ptr_q;
  logic [LED_IDX_W-1:0]   rd_led_q;
  logic [LED_COUNT-1:0]   led_valid_q;
  logic                   supply_q;

  logic                   ser_busy;
  ser_load_t              ser_load;
  logic                   in_fire;

  // Pixel write address decode.
  logic                   in_grid;
  logic [POS_W-1:0]       pos;
  logic [MAP_VAL_W-1:0]   map_val;
  logic                   map_hit;
  logic                   pix_we;
  logic [LED_IDX_W-1:0]   pix_led;
  logic [PIXEL_W-1:0]     pix_color;

  // Refresh read side.
  logic [LED_IDX_W-1:0]   send_led;
  logic                   rd_en;
  logic [PIXEL_W-1:0]     rd_data;

  assign in_i.ready = (state_q == ST_IDLE) && !ser_busy;
  assign in_fire    = in_i.valid && in_i.ready;

  // The supply enable is only stored and reflected back to the pin.
  assign cfg_i.ready        = 1'b1;
  assign cfg_i.supply_level = supply_q;

  always_comb begin
    in_grid = (COL_W'(in_i.column) < COL_W'(GRID_COLUMNS)) &&
              (ROW_W'(in_i.row) < ROW_W'(GRID_ROWS));
    pos     = POS_W'(POS_W'(in_i.row) * POS_W'(GRID_COLUMNS)) + POS_W'(in_i.column);
    map_val = '0;
    map_hit = 1'b0;
    if (in_grid && (pos < POS_W'(MAP_LEN))) begin
      map_val = KEY_TO_LED[pos[MAP_IDX_W-1:0]];
      // Table entries past the end of the chain are dropped.
      map_hit = (map_val < MAP_VAL_W'(LED_COUNT));
    end
    pix_led   = map_val[LED_IDX_W-1:0];
    pix_color = {in_i.green, in_i.red, in_i.blue};
    pix_we    = in_fire && (in_i.kind == KIND_WRITE) && map_hit;
  end

  // A pointer that somehow sits beyond the chain restarts at the first LED.
  assign send_led = (ptr_q < LED_IDX_W'(LED_COUNT)) ? ptr_q : '0;
  assign rd_en    = in_fire && (in_i.kind == KIND_REFRESH);

  lmf_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (LED_COUNT)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_led),
    .wdata_i (pix_color),
    .re_i    (rd_en),
    .raddr_i (send_led),
    .rdata_o (rd_data)
  );

  // An LED never written since reset or the last clear reads as black.
  always_comb begin
    ser_load.valid     = (state_q == ST_READ);
    ser_load.color     = led_valid_q[rd_led_q] ? rd_data : '0;
    ser_load.final_led = (rd_led_q == LED_IDX_W'(LED_COUNT - 1));
  end

  lmf_serializer u_serializer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ser_load),
    .busy_o (ser_busy),
    .out_o  (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      rd_led_q    <= '0;
      led_valid_q <= '0;
      supply_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        supply_q <= cfg_i.supply_enable;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_i.kind)
              KIND_WRITE: begin
                if (map_hit) begin
                  led_valid_q[pix_led] <= 1'b1;
                end
              end
              KIND_CLEAR: begin
                led_valid_q <= '0;
              end
              KIND_REFRESH: begin
                rd_led_q <= send_led;
                ptr_q    <= (send_led == LED_IDX_W'(LED_COUNT - 1)) ? '0 : send_led + 1'b1;
                state_q  <= ST_READ;
              end
              default: begin
                // The unused kind is taken and dropped.
              end
            endcase
          end
        end
        ST_READ: begin
          // The serializer is idle here and takes the color at this edge.
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
